@@ design/sfl_pkg.sv @@
// Shared types and constants for the symbol floor lookup block.
package sfl_pkg;

  localparam int ADDR_W  = 32;  // symbol and query address width
  localparam int CNT_W   = 11;  // symbol count and scan index width
  localparam int IDX_W   = 10;  // entry index field width
  localparam int CFG_I_W = 2;   // configuration register index width

  localparam logic [CFG_I_W-1:0] CFG_TEXT_START   = 2'd0;
  localparam logic [CFG_I_W-1:0] CFG_TEXT_END     = 2'd1;
  localparam logic [CFG_I_W-1:0] CFG_SYMBOL_COUNT = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FETCH,
    S_TAIL
  } state_t;

endpackage

@@ design/sfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/symbol_floor_lookup.sv @@
// Top level: predecessor search over a table of symbol start addresses.
//
//  port group  | direction | handshake                 | contents
//  ------------+-----------+---------------------------+-------------------------------
//  in_*        | in        | start high, busy low      | mode, entry index, address
//  out_*       | out       | out_valid, one cycle      | found, index, offset, size
//  cfg_*       | in        | cfg_we, no wait           | text start, text end, count
//
// A load request is written to the table at its accept edge; busy stays low.
// A lookup outside [text_start, text_end] strobes its result the next cycle.
// A lookup inside the range reads max(count,1) entries, count saturated to
// TABLE_DEPTH: one RAM read per entry through a single comparator, then one
// read of the following entry and a shared subtractor for offset and size.
// Synchronous active-low reset clears control and config; no table clear.
// The receiver cannot stall: out_valid marks each result for one cycle.
module symbol_floor_lookup
  import sfl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [ADDR_W-1:0]   in_address_value,
  output logic                out_valid,
  output logic                out_found,
  output logic [IDX_W-1:0]    out_symbol_index,
  output logic [ADDR_W-1:0]   out_symbol_offset,
  output logic [ADDR_W-1:0]   out_symbol_size,
  input  logic                cfg_we,
  input  logic [CFG_I_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] text_start_r, text_end_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] query_r;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [ADDR_W-1:0] best_addr_r, best_addr_nxt;
  logic              tail_sel_r;
  logic [ADDR_W-1:0] offset_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [ADDR_W-1:0] out_offset_r, out_size_r;

  logic              accept, in_range, do_load, do_lookup;
  logic [CNT_W-1:0]  count_sat, last_idx, best_inc;
  logic              scan_issue, fetch_issue, tail_done;
  logic [CNT_W-1:0]  rd_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_rdata;
  logic              cmp_take;
  logic [ADDR_W-1:0] sub_a, diff;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (in_address_value >= text_start_r) && (in_address_value <= text_end_r);
  assign do_load   = accept && (in_mode == MODE_LOAD);
  assign do_lookup = accept && (in_mode == MODE_LOOKUP);

  // loads past the table are dropped
  assign ram_we = do_load && ({{(32-IDX_W){1'b0}}, in_entry_index} < DEPTH_W);

  always_comb begin
    if ({{(32-CNT_W){1'b0}}, count_r} > DEPTH_W) begin
      count_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      count_sat = count_r;
    end
  end

  // entry 0 is always read, even with an empty table
  assign last_idx = (count_sat == '0) ? '0 : count_sat - 1'b1;
  assign best_inc = best_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (do_lookup && in_range) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx_r == last_idx) state_nxt = S_LAST;
      end
      S_LAST:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_issue  = 1'b0;
    fetch_issue = 1'b0;
    tail_done   = 1'b0;
    unique case (state_r)
      S_IDLE:  ;
      S_SCAN:  scan_issue  = 1'b1;
      S_LAST:  ;
      S_FETCH: fetch_issue = 1'b1;
      S_TAIL:  tail_done   = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr = fetch_issue ? best_inc : scan_idx_r;

  sfl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_address_value),
    .raddr (AW'(rd_addr)),
    .rdata (ram_rdata)
  );

  // shared comparator: entry 0 seeds the search, ties keep the earlier entry
  assign cmp_take = rd_vld_r &&
                    ((rd_idx_r == '0) || ((ram_rdata > best_addr_r) && (ram_rdata <= query_r)));

  // shared subtractor: offset in FETCH, size in TAIL
  assign sub_a = tail_done ? (tail_sel_r ? ram_rdata : text_end_r) : query_r;
  assign diff  = sub_a - best_addr_r;

  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = scan_issue;
    best_nxt      = best_r;
    best_addr_nxt = best_addr_r;
    out_valid_nxt = tail_done || (do_lookup && !in_range);
    if (do_lookup) scan_idx_nxt = '0;
    else if (scan_issue) scan_idx_nxt = scan_idx_r + 1'b1;
    if (cmp_take) begin
      best_nxt      = rd_idx_r;
      best_addr_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      text_start_r <= '0;
      text_end_r   <= '0;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TEXT_START:   text_start_r <= cfg_data;
          CFG_TEXT_END:     text_end_r   <= cfg_data;
          CFG_SYMBOL_COUNT: count_r      <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= scan_idx_r;
    best_r      <= best_nxt;
    best_addr_r <= best_addr_nxt;
    if (do_lookup) query_r <= in_address_value;
    if (fetch_issue) begin
      offset_r   <= diff;
      tail_sel_r <= (best_inc < count_sat);
    end
    if (do_lookup && !in_range) begin
      out_found_r  <= 1'b0;
      out_index_r  <= '0;
      out_offset_r <= '0;
      out_size_r   <= '0;
    end else if (tail_done) begin
      out_found_r  <= 1'b1;
      out_index_r  <= best_r[IDX_W-1:0];
      out_offset_r <= offset_r;
      out_size_r   <= diff;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_symbol_index  = out_index_r;
  assign out_symbol_offset = out_offset_r;
  assign out_symbol_size   = out_size_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobed while sequencer busy");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_symbol_index == '0 && out_symbol_offset == '0 && out_symbol_size == '0))
    else $error("out-of-range result not cleared");

  a_lookup_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_LOOKUP) |=> (out_valid || busy))
    else $error("lookup request neither answered nor started");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_LOAD) |=> !out_valid)
    else $error("load request produced a result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= last_idx))
    else $error("scan index ran past last entry");

endmodule
